FILE: hw/rtl/bresenham_line_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line rasterizer
// Concurrent assertion wrappers that compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BLR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rasterizer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rasterizer assertion failed");

`else

`define BLR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Request codes and the color width shared by the rasterizer files.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

  // Width of the color carried with each line.
  localparam int COLOR_BITS = 24;

  // Request kinds on the input channel.
  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// Loads a line from two endpoints and emits one pixel per step request.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) takes requests. A start request
// (in_mode = start) loads both endpoints and a color and produces no output.
// A step request produces one pixel on the output channel (out_valid/
// out_ready) while a line is active; the final pixel carries out_last_pixel.
// The far endpoint on the major axis is not drawn, so a line yields |dmajor|
// pixels; a zero-length line and a step with no active line yield nothing.
// A start while a line is active abandons it and loads the new one.
// A pixel appears on the output in the cycle after its step request is taken.
// Throughput: one request per cycle unless the receiver stalls; the single
// result register is the only stage, and a step updates the decision term.
// When the receiver stalls with a pixel pending, in_ready drops until that
// pixel is taken; it stays high while the pixel is being taken.
// Reset (rst_n low, synchronous) leaves the block idle with no pixel pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_rasterizer_assert.svh"

module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 10
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // Request channel
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           in_mode,
  input  wire  [COORD_BITS-1:0]         in_start_x,
  input  wire  [COORD_BITS-1:0]         in_start_y,
  input  wire  [COORD_BITS-1:0]         in_end_x,
  input  wire  [COORD_BITS-1:0]         in_end_y,
  input  wire  [blr_pkg::COLOR_BITS-1:0] in_draw_color,
  // Pixel channel
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [COORD_BITS-1:0]         out_pixel_x,
  output logic [COORD_BITS-1:0]         out_pixel_y,
  output logic [blr_pkg::COLOR_BITS-1:0] out_pixel_color,
  output logic                          out_last_pixel
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 3;
  localparam logic [CB-1:0] ONE = CB'(1);

  // Line state
  logic [CB-1:0]                  major_pos_r, major_pos_nxt;
  logic [CB-1:0]                  minor_pos_r, minor_pos_nxt;
  logic signed [DW-1:0]           decision_r, decision_nxt;
  logic [CB-1:0]                  pixels_left_r, pixels_left_nxt;
  logic                           minor_neg_r, minor_neg_nxt;
  logic                           y_major_r, y_major_nxt;
  logic [CB:0]                    twice_minor_r, twice_minor_nxt;
  logic [CB:0]                    twice_major_r, twice_major_nxt;
  logic [blr_pkg::COLOR_BITS-1:0] held_color_r, held_color_nxt;
  logic                           busy_r, busy_nxt;

  // Result register
  logic                           out_valid_r, out_valid_nxt;
  logic [CB-1:0]                  pix_x_r, pix_x_nxt;
  logic [CB-1:0]                  pix_y_r, pix_y_nxt;
  logic [blr_pkg::COLOR_BITS-1:0] pix_color_r, pix_color_nxt;
  logic                           pix_last_r, pix_last_nxt;

  logic in_fire;
  logic is_step;
  logic emit;

  // Start setup
  logic [CB:0]          dx_s, dy_s;
  logic [CB-1:0]        neg_dx, neg_dy;
  logic [CB-1:0]        adx, ady;
  logic                 ld_ymaj, ld_swap, ld_neg;
  logic [CB-1:0]        ld_maj0, ld_min0, ld_dmaj, ld_dmin;
  logic signed [DW-1:0] ld_decision;

  // Step arithmetic
  logic                 dec_pos;
  logic signed [DW-1:0] minor_term, major_term;
  logic                 step_last;

  // Handshake: a new request is taken unless a pixel is stuck at the output.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_step  = (in_mode == blr_pkg::MODE_STEP);
  assign emit     = in_fire && is_step && busy_r;

  // Deltas and their magnitudes.
  assign dx_s   = {1'b0, in_end_x} - {1'b0, in_start_x};
  assign dy_s   = {1'b0, in_end_y} - {1'b0, in_start_y};
  assign neg_dx = -dx_s[CB-1:0];
  assign neg_dy = -dy_s[CB-1:0];
  assign adx    = dx_s[CB] ? neg_dx : dx_s[CB-1:0];
  assign ady    = dy_s[CB] ? neg_dy : dy_s[CB-1:0];

  // Pick the major axis and order the endpoints so the major coordinate rises.
  always_comb begin
    ld_ymaj = (ady >= adx);
    if (ld_ymaj) begin
      ld_swap = (in_start_y > in_end_y);
      ld_maj0 = ld_swap ? in_end_y : in_start_y;
      ld_min0 = ld_swap ? in_end_x : in_start_x;
      ld_dmaj = ady;
      ld_dmin = adx;
      ld_neg  = ld_swap ? (in_end_x > in_start_x) : dx_s[CB];
    end else begin
      ld_swap = (in_start_x > in_end_x);
      ld_maj0 = ld_swap ? in_end_x : in_start_x;
      ld_min0 = ld_swap ? in_end_y : in_start_y;
      ld_dmaj = adx;
      ld_dmin = ady;
      ld_neg  = ld_swap ? (in_end_y > in_start_y) : dy_s[CB];
    end
    ld_decision = $signed({2'b00, ld_dmin, 1'b0}) - $signed({3'b000, ld_dmaj});
  end

  // Decision update for one step.
  assign dec_pos    = !decision_r[DW-1] && (decision_r != '0);
  assign minor_term = $signed({2'b00, twice_minor_r});
  assign major_term = dec_pos ? $signed({2'b00, twice_major_r}) : '0;
  assign step_last  = (pixels_left_r == ONE);

  // Next line state.
  always_comb begin
    major_pos_nxt   = major_pos_r;
    minor_pos_nxt   = minor_pos_r;
    decision_nxt    = decision_r;
    pixels_left_nxt = pixels_left_r;
    minor_neg_nxt   = minor_neg_r;
    y_major_nxt     = y_major_r;
    twice_minor_nxt = twice_minor_r;
    twice_major_nxt = twice_major_r;
    held_color_nxt  = held_color_r;
    busy_nxt        = busy_r;
    if (in_fire && !is_step) begin
      major_pos_nxt   = ld_maj0;
      minor_pos_nxt   = ld_min0;
      decision_nxt    = ld_decision;
      pixels_left_nxt = ld_dmaj;
      minor_neg_nxt   = ld_neg;
      y_major_nxt     = ld_ymaj;
      twice_minor_nxt = {ld_dmin, 1'b0};
      twice_major_nxt = {ld_dmaj, 1'b0};
      held_color_nxt  = in_draw_color;
      busy_nxt        = (ld_dmaj != '0);
    end else if (emit) begin
      if (dec_pos) begin
        minor_pos_nxt = minor_neg_r ? (minor_pos_r - ONE) : (minor_pos_r + ONE);
      end
      decision_nxt    = decision_r - major_term + minor_term;
      major_pos_nxt   = major_pos_r + ONE;
      pixels_left_nxt = pixels_left_r - ONE;
      busy_nxt        = !step_last;
    end
  end

  // Next result register contents.
  always_comb begin
    out_valid_nxt = out_valid_r;
    pix_x_nxt     = pix_x_r;
    pix_y_nxt     = pix_y_r;
    pix_color_nxt = pix_color_r;
    pix_last_nxt  = pix_last_r;
    if (in_fire) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      pix_x_nxt     = y_major_r ? minor_pos_r : major_pos_r;
      pix_y_nxt     = y_major_r ? major_pos_r : minor_pos_r;
      pix_color_nxt = held_color_r;
      pix_last_nxt  = step_last;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    major_pos_r   <= major_pos_nxt;
    minor_pos_r   <= minor_pos_nxt;
    decision_r    <= decision_nxt;
    pixels_left_r <= pixels_left_nxt;
    minor_neg_r   <= minor_neg_nxt;
    y_major_r     <= y_major_nxt;
    twice_minor_r <= twice_minor_nxt;
    twice_major_r <= twice_major_nxt;
    held_color_r  <= held_color_nxt;
    pix_x_r       <= pix_x_nxt;
    pix_y_r       <= pix_y_nxt;
    pix_color_r   <= pix_color_nxt;
    pix_last_r    <= pix_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pix_x_r;
  assign out_pixel_y     = pix_y_r;
  assign out_pixel_color = pix_color_r;
  assign out_last_pixel  = pix_last_r;

  // An active line always has pixels left to emit.
  `BLR_ASSERT_SAME(a_busy_has_pixels, clk, rst_n, busy_r, pixels_left_r != '0)
  // Emitting the last pixel ends the line.
  `BLR_ASSERT_NEXT(a_last_ends_line, clk, rst_n, emit && step_last, !busy_r)
  // A start request never produces a pixel.
  `BLR_ASSERT_NEXT(a_start_silent, clk, rst_n, in_fire && !is_step, !out_valid_r)
  // A step with no active line produces nothing.
  `BLR_ASSERT_NEXT(a_idle_step_silent, clk, rst_n, in_fire && is_step && !busy_r, !out_valid_r)

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Sends start and step requests through the request channel and checks each
// emitted pixel against a typed table row's answer or else a line-walking
// predictor kept inside this module. A short directed table covers the edge
// cases. A random stream of short, well-formed lines with random endpoints
// and colors follows, mixed with abandoned lines, idle steps and noise. Both
// channels stall at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CB          = 10;
  localparam int COORD_MAX   = (1 << CB) - 1;
  localparam int COLOR_MAX   = (1 << blr_pkg::COLOR_BITS) - 1;
  localparam int ITEM_TARGET = 750;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;

  // One request as driven on the input channel.
  typedef struct {
    blr_pkg::mode_t                 mode;
    logic [CB-1:0]                  start_x;
    logic [CB-1:0]                  start_y;
    logic [CB-1:0]                  end_x;
    logic [CB-1:0]                  end_y;
    logic [blr_pkg::COLOR_BITS-1:0] color;
  } request_t;

  // One pixel as seen on the output channel.
  typedef struct {
    logic [CB-1:0]                  x;
    logic [CB-1:0]                  y;
    logic [blr_pkg::COLOR_BITS-1:0] color;
    logic                           is_last;
  } pixel_t;

  // A row of the directed table; typed rows carry their answer directly.
  typedef struct {
    request_t req;
    bit       typed;
    bit       emits;
    pixel_t   px;
  } table_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_mode = blr_pkg::MODE_START;
  logic [CB-1:0]                  in_start_x = '0;
  logic [CB-1:0]                  in_start_y = '0;
  logic [CB-1:0]                  in_end_x = '0;
  logic [CB-1:0]                  in_end_y = '0;
  logic [blr_pkg::COLOR_BITS-1:0] in_draw_color = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [CB-1:0]                  out_pixel_x;
  logic [CB-1:0]                  out_pixel_y;
  logic [blr_pkg::COLOR_BITS-1:0] out_pixel_color;
  logic                           out_last_pixel;

  // Predicted line state.
  logic [CB-1:0]                  ln_major;
  logic [CB-1:0]                  ln_minor;
  logic signed [CB+2:0]           ln_decision;
  logic [CB-1:0]                  ln_left;
  bit                             ln_minor_down;
  bit                             ln_y_major;
  logic [CB:0]                    ln_twice_minor;
  logic [CB:0]                    ln_twice_major;
  logic [blr_pkg::COLOR_BITS-1:0] ln_color;
  bit                             ln_active;

  pixel_t     expected_pixels[$];
  pixel_t     head_pixel;
  table_row_t directed_rows[$];

  int error_count = 0;
  int pixels_checked = 0;
  int requests_sent = 0;
  int lines_started = 0;
  int long_holds = 0;
  int cycle_count = 0;
  int sender_burst = 0;
  int receiver_burst = 0;
  bit long_hold_req = 1'b0;

  bresenham_line_rasterizer #(
    .COORD_BITS(CB)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_draw_color  (in_draw_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_color(out_pixel_color),
    .out_last_pixel (out_last_pixel)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int magnitude_of(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // Wait before the next request or pixel: usually a random wait, with
  // occasional bursts that do not wait at all.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic request_t random_request(blr_pkg::mode_t m);
    request_t r;
    r.mode    = m;
    r.start_x = CB'($urandom_range(0, COORD_MAX));
    r.start_y = CB'($urandom_range(0, COORD_MAX));
    r.end_x   = CB'($urandom_range(0, COORD_MAX));
    r.end_y   = CB'($urandom_range(0, COORD_MAX));
    r.color   = blr_pkg::COLOR_BITS'($urandom_range(0, COLOR_MAX));
    return r;
  endfunction

  function automatic void add_row(blr_pkg::mode_t m, int sx, int sy, int ex, int ey,
                                  int col, bit typed, bit emits, int px, int py, int pc,
                                  bit pl);
    table_row_t row;
    row.req.mode     = m;
    row.req.start_x  = CB'(sx);
    row.req.start_y  = CB'(sy);
    row.req.end_x    = CB'(ex);
    row.req.end_y    = CB'(ey);
    row.req.color    = blr_pkg::COLOR_BITS'(col);
    row.typed        = typed;
    row.emits        = emits;
    row.px.x         = CB'(px);
    row.px.y         = CB'(py);
    row.px.color     = blr_pkg::COLOR_BITS'(pc);
    row.px.is_last   = pl;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Line walker: a start loads the line, a step on an active line yields
  // the next pixel and advances the decision term.
  task automatic walk_line(input request_t r, output bit emitted, output pixel_t px);
    int  xa, ya, xb, yb;
    int  maj0, min0, dmaj, dmin;
    bit  ymaj;
    emitted = 1'b0;
    px      = '{default: '0};
    if (r.mode == blr_pkg::MODE_START) begin
      xa = r.start_x;
      ya = r.start_y;
      xb = r.end_x;
      yb = r.end_y;
      ymaj = magnitude_of(yb - ya) >= magnitude_of(xb - xa);
      if (ymaj) begin
        if (ya > yb) begin
          maj0 = yb; min0 = xb; dmaj = ya - yb; dmin = xa - xb;
        end else begin
          maj0 = ya; min0 = xa; dmaj = yb - ya; dmin = xb - xa;
        end
      end else begin
        if (xa > xb) begin
          maj0 = xb; min0 = yb; dmaj = xa - xb; dmin = ya - yb;
        end else begin
          maj0 = xa; min0 = ya; dmaj = xb - xa; dmin = yb - ya;
        end
      end
      ln_color       = r.color;
      ln_y_major     = ymaj;
      ln_minor_down  = dmin < 0;
      dmin           = magnitude_of(dmin);
      ln_major       = CB'(maj0);
      ln_minor       = CB'(min0);
      ln_twice_minor = (CB + 1)'(2 * dmin);
      ln_twice_major = (CB + 1)'(2 * dmaj);
      ln_decision    = (CB + 3)'(2 * dmin - dmaj);
      ln_left        = CB'(dmaj);
      ln_active      = dmaj != 0;
    end else if (ln_active) begin
      px.x       = ln_y_major ? ln_minor : ln_major;
      px.y       = ln_y_major ? ln_major : ln_minor;
      px.color   = ln_color;
      px.is_last = ln_left == CB'(1);
      emitted    = 1'b1;
      if (ln_decision > 0) begin
        ln_minor    = ln_minor_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
        ln_decision = (CB + 3)'(int'(ln_decision) - int'(ln_twice_major));
      end
      ln_decision = (CB + 3)'(int'(ln_decision) + int'(ln_twice_minor));
      ln_major    = ln_major + 1'b1;
      ln_left     = ln_left - 1'b1;
      if (px.is_last) begin
        ln_active = 1'b0;
      end
    end
  endtask

  // Drive one request, wait for its handshake and record what it should
  // produce. Called and returns at a falling edge.
  task automatic send_request(input request_t r, input bit typed, input bit typed_emit,
                              input pixel_t typed_px, output bit emitted);
    int     gap;
    bit     hit;
    pixel_t px;
    gap = draw_wait(sender_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= r.mode;
    in_start_x    <= r.start_x;
    in_start_y    <= r.start_y;
    in_end_x      <= r.end_x;
    in_end_y      <= r.end_y;
    in_draw_color <= r.color;
    do @(posedge clk); while (!in_ready);
    walk_line(r, hit, px);
    if (typed) begin
      hit = typed_emit;
      px  = typed_px;
    end
    if (hit) begin
      expected_pixels.push_back(px);
    end
    emitted = hit;
    requests_sent++;
    if (r.mode == blr_pkg::MODE_START) begin
      lines_started++;
    end
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_holds++;
        hold = HOLD_CYCLES;
      end else begin
        hold = draw_wait(receiver_burst);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Pixel checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel (%0d,%0d) with no request pending",
               out_pixel_x, out_pixel_y);
        error_count++;
      end else begin
        head_pixel = expected_pixels.pop_front();
        check_field("pixel_x", head_pixel.x, out_pixel_x);
        check_field("pixel_y", head_pixel.y, out_pixel_y);
        check_field("pixel_color", head_pixel.color, out_pixel_color);
        check_field("last_pixel", head_pixel.is_last, out_last_pixel);
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    request_t r;
    pixel_t   none_px;
    bit       hit;
    bit       hold_asked;
    int       counted;
    int       kind;
    int       span;
    int       steps;
    int       dmaj;

    none_px    = '{default: '0};
    hold_asked = 1'b0;
    counted    = 0;

    // Directed table.
    // Step while idle after reset, with every field at its top value.
    add_row(blr_pkg::MODE_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COLOR_MAX,
            1, 0, 0, 0, 0, 0);
    // Short x-major line at the top corner, given right to left.
    add_row(blr_pkg::MODE_START, 1023, 1023, 1020, 1023, 24'hFFFFFF, 1, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 1, 1, 1020, 1023, 24'hFFFFFF, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 1, 1, 1021, 1023, 24'hFFFFFF, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 1, 1, 1022, 1023, 24'hFFFFFF, 1);
    // Step after the line is finished.
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    // Zero-length line never emits.
    add_row(blr_pkg::MODE_START, 512, 512, 512, 512, 0, 1, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    // Equal deltas pick y as the major axis.
    add_row(blr_pkg::MODE_START, 0, 0, 2, 2, 24'h000001, 1, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 1, 1, 0, 0, 24'h000001, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 1, 1, 1, 1, 24'h000001, 1);
    // Minor axis stepping down.
    add_row(blr_pkg::MODE_START, 0, 1023, 3, 1020, 24'hA5A5A5, 0, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // Long line, step fields ignored, then abandoned by a new start.
    add_row(blr_pkg::MODE_START, 0, 0, 1023, 5, 24'h5A5A5A, 0, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COLOR_MAX,
            0, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_START, 1023, 0, 1000, 1023, 24'h123456, 0, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // Full-height vertical line.
    add_row(blr_pkg::MODE_START, 0, 0, 0, 1023, 24'hFFFFFF, 1, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 1, 1, 0, 0, 24'hFFFFFF, 0);
    // Full-width horizontal line given right to left.
    add_row(blr_pkg::MODE_START, 1023, 0, 0, 0, 24'h00FF00, 0, 0, 0, 0, 0, 0);
    add_row(blr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    // Hold reset, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].emits,
                   directed_rows[i].px, hit);
    end

    // Random part: mostly short complete lines, some long abandoned lines
    // and some noise requests.
    while (counted < ITEM_TARGET) begin
      if (!hold_asked && counted >= 300) begin
        long_hold_req = 1'b1;
        hold_asked    = 1'b1;
      end
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        r = random_request(blr_pkg::mode_t'($urandom_range(0, 1)));
        send_request(r, 0, 0, none_px, hit);
        if (hit || r.mode == blr_pkg::MODE_START) begin
          counted++;
        end
      end else begin
        r = random_request(blr_pkg::MODE_START);
        if (kind == 1) begin
          steps = $urandom_range(0, 30);
        end else begin
          span    = ($urandom_range(0, 3) == 0) ? 40 : 12;
          r.end_x = CB'(clamp_coord(int'(r.start_x) + $urandom_range(0, 2 * span) - span));
          r.end_y = CB'(clamp_coord(int'(r.start_y) + $urandom_range(0, 2 * span) - span));
          dmaj    = magnitude_of(int'(r.end_x) - int'(r.start_x));
          if (magnitude_of(int'(r.end_y) - int'(r.start_y)) > dmaj) begin
            dmaj = magnitude_of(int'(r.end_y) - int'(r.start_y));
          end
          steps = dmaj + $urandom_range(0, 4) - 2;
          if (steps < 0) begin
            steps = 0;
          end
        end
        send_request(r, 0, 0, none_px, hit);
        counted++;
        repeat (steps) begin
          send_request(random_request(blr_pkg::MODE_STEP), 0, 0, none_px, hit);
          if (hit) begin
            counted++;
          end
        end
      end
    end

    // Drain the pixel channel and leave room for any stray output.
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);

    $display("Run covered %0d requests over %0d line starts; %0d pixels checked.",
             requests_sent, lines_started, pixels_checked);
    $display("Receiver long hold-offs: %0d; mismatches: %0d.", long_holds, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
